### design/lcmn_pkg.sv
// Shared constants, register codes and control/status types of the cepstral mean normalizer.
package lcmn_pkg;

    localparam int DEFAULT_MAX_COEFFS = 32;

    localparam int COEFF_W   = 16;
    localparam int SUM_W     = 40;
    localparam int FRAME_W   = 16;
    localparam int CNT_CFG_W = 6;
    localparam int DIV_W     = SUM_W + FRAME_W;
    localparam int ITER_W    = $clog2(DIV_W);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_COEFF_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_WATER  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_C0_MEAN     = 2'd3;

    localparam logic [CNT_CFG_W-1:0] RST_COEFF_COUNT = 6'd13;
    localparam logic [FRAME_W-1:0]   RST_WINDOW      = 16'd500;
    localparam logic [FRAME_W-1:0]   RST_HIGH_WATER  = 16'd800;
    localparam logic [COEFF_W-1:0]   RST_C0_MEAN     = 16'd3072;

    typedef struct packed {
        logic rd_item;
        logic calc;
        logic sweep_clr;
        logic sweep_inc;
        logic rd_sweep;
        logic div_load_mean;
        logic div_load_decay;
        logic div_step;
        logic mul_load;
        logic mul_step;
        logic wr_mean;
        logic wr_sum;
        logic cnt_window;
    } lcmn_cmd_t;

    typedef struct packed {
        logic eob;
        logic eou;
        logic cnt_gt_hwm;
        logic cnt_zero;
        logic sweep_last;
        logic iter_zero;
        logic out_free;
    } lcmn_stat_t;

endpackage

### design/lcmn_datapath.sv
// Datapath: coefficient stores, accumulate and subtract, shift-add multiplier and divider.
module lcmn_datapath import lcmn_pkg::*; #(
    parameter int MAX_COEFFS = DEFAULT_MAX_COEFFS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lcmn_cmd_t             cmd,
    output lcmn_stat_t            stat,
    input  logic [COEFF_W-1:0]    s_coeff_in,
    input  logic                  s_end_of_batch,
    input  logic                  s_end_of_utterance,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COEFF_W-1:0]    m_coeff_out,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int IDX_W  = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
    localparam int NW_MIN = $clog2(MAX_COEFFS + 1);
    localparam int NW     = (NW_MIN > CNT_CFG_W) ? NW_MIN : CNT_CFG_W;

    localparam logic [DIV_W-1:0] MEAN_POS_MAX = DIV_W'(32767);
    localparam logic [DIV_W-1:0] MEAN_NEG_MAX = DIV_W'(32768);
    localparam logic [DIV_W-1:0] SUM_POS_MAX  = {{(DIV_W-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
    localparam logic [DIV_W-1:0] SUM_NEG_MAX  = SUM_POS_MAX + DIV_W'(1);

    logic [CNT_CFG_W-1:0] cfg_count_reg;
    logic [FRAME_W-1:0]   window_reg;
    logic [FRAME_W-1:0]   hwm_reg;
    logic [COEFF_W-1:0]   c0_mean_reg;

    logic [SUM_W-1:0]   sum_mem_reg  [MAX_COEFFS];
    logic [COEFF_W-1:0] mean_mem_reg [MAX_COEFFS];
    logic [MAX_COEFFS-1:0] sum_vld_reg;
    logic [MAX_COEFFS-1:0] mean_vld_reg;

    logic [SUM_W-1:0]   rd_sum_reg;
    logic [COEFF_W-1:0] rd_mean_reg;

    logic [COEFF_W-1:0] x_reg;
    logic               eob_reg;
    logic               eou_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   coeff_index_reg;
    logic [IDX_W-1:0]   coeff_index_next;
    logic [FRAME_W-1:0] frame_count_reg;
    logic [FRAME_W-1:0] frame_count_next;
    logic [IDX_W-1:0]   sweep_idx_reg;

    logic [DIV_W-1:0]   dq_reg;
    logic [FRAME_W-1:0] rem_reg;
    logic [DIV_W-1:0]   prod_reg;
    logic [FRAME_W-1:0] wmul_reg;
    logic [ITER_W-1:0]  iter_reg;

    logic               m_valid_reg;
    logic [COEFF_W-1:0] m_coeff_reg;

    logic [NW-1:0]      n_raw;
    logic [NW-1:0]      n_eff;
    logic [IDX_W-1:0]   eff_idx;
    logic [NW-1:0]      idx_inc;
    logic               wrap;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;

    logic [COEFF_W:0]   diff;
    logic [COEFF_W-1:0] diff_sat;
    logic [SUM_W:0]     sum_add;
    logic [SUM_W-1:0]   sum_add_sat;

    logic               sum_neg;
    logic [SUM_W-1:0]   sum_mag;
    logic [DIV_W-1:0]   half;
    logic [FRAME_W:0]   trial;
    logic               ge;
    logic [COEFF_W-1:0] mean_val;
    logic [SUM_W-1:0]   decay_val;
    logic [SUM_W-1:0]   sum_wdata;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_count_reg <= RST_COEFF_COUNT;
            window_reg    <= RST_WINDOW;
            hwm_reg       <= RST_HIGH_WATER;
            c0_mean_reg   <= RST_C0_MEAN;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_COEFF_COUNT: cfg_count_reg <= cfg_wdata[CNT_CFG_W-1:0];
                REG_WINDOW:      window_reg    <= cfg_wdata;
                REG_HIGH_WATER:  hwm_reg       <= cfg_wdata;
                REG_C0_MEAN:     c0_mean_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_raw = NW'(cfg_count_reg);
        if (n_raw == '0) begin
            n_eff = NW'(1);
        end else if (n_raw > NW'(MAX_COEFFS)) begin
            n_eff = NW'(MAX_COEFFS);
        end else begin
            n_eff = n_raw;
        end
    end

    assign eff_idx = (NW'(coeff_index_reg) >= n_eff) ? '0 : coeff_index_reg;
    assign idx_inc = NW'(idx_reg) + NW'(1);
    assign wrap    = eob_reg || (idx_inc >= n_eff);
    assign rd_addr = cmd.rd_sweep ? sweep_idx_reg : eff_idx;
    assign wr_addr = cmd.calc ? idx_reg : sweep_idx_reg;

    // accumulate and subtract
    always_comb begin
        diff = {x_reg[COEFF_W-1], x_reg} - {rd_mean_reg[COEFF_W-1], rd_mean_reg};
        if (diff[COEFF_W] != diff[COEFF_W-1]) begin
            diff_sat = {diff[COEFF_W], {(COEFF_W-1){~diff[COEFF_W]}}};
        end else begin
            diff_sat = diff[COEFF_W-1:0];
        end
        sum_add = {rd_sum_reg[SUM_W-1], rd_sum_reg}
                + {{(SUM_W-COEFF_W+1){x_reg[COEFF_W-1]}}, x_reg};
        if (sum_add[SUM_W] != sum_add[SUM_W-1]) begin
            sum_add_sat = {sum_add[SUM_W], {(SUM_W-1){~sum_add[SUM_W]}}};
        end else begin
            sum_add_sat = sum_add[SUM_W-1:0];
        end
    end

    // rounding, divider step and result saturation
    always_comb begin
        sum_neg = rd_sum_reg[SUM_W-1];
        sum_mag = sum_neg ? (SUM_W'(0) - rd_sum_reg) : rd_sum_reg;
        half    = DIV_W'(frame_count_reg >> 1);
        trial   = {rem_reg, dq_reg[DIV_W-1]};
        ge      = (trial >= {1'b0, frame_count_reg});
        if (!sum_neg) begin
            mean_val  = (dq_reg > MEAN_POS_MAX) ? MEAN_POS_MAX[COEFF_W-1:0]
                                                : dq_reg[COEFF_W-1:0];
            decay_val = (dq_reg > SUM_POS_MAX) ? SUM_POS_MAX[SUM_W-1:0]
                                               : dq_reg[SUM_W-1:0];
        end else begin
            mean_val  = (dq_reg > MEAN_NEG_MAX) ? MEAN_NEG_MAX[COEFF_W-1:0]
                                                : (COEFF_W'(0) - dq_reg[COEFF_W-1:0]);
            decay_val = (dq_reg > SUM_NEG_MAX) ? SUM_NEG_MAX[SUM_W-1:0]
                                               : (SUM_W'(0) - dq_reg[SUM_W-1:0]);
        end
        sum_wdata = cmd.calc ? sum_add_sat : decay_val;
    end

    // stores
    always_ff @(posedge aclk) begin
        if (cmd.calc || cmd.wr_sum) begin
            sum_mem_reg[wr_addr] <= sum_wdata;
        end
        if (cmd.wr_mean) begin
            mean_mem_reg[sweep_idx_reg] <= mean_val;
        end
        if (cmd.rd_item || cmd.rd_sweep) begin
            rd_sum_reg <= sum_vld_reg[rd_addr] ? sum_mem_reg[rd_addr] : '0;
            if (mean_vld_reg[rd_addr]) begin
                rd_mean_reg <= mean_mem_reg[rd_addr];
            end else begin
                rd_mean_reg <= (rd_addr == '0) ? c0_mean_reg : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_vld_reg  <= '0;
            mean_vld_reg <= '0;
        end else begin
            if (cmd.calc || cmd.wr_sum) begin
                sum_vld_reg[wr_addr] <= 1'b1;
            end
            if (cmd.wr_mean) begin
                mean_vld_reg[sweep_idx_reg] <= 1'b1;
            end
            if (cfg_wr_en && cfg_addr == REG_C0_MEAN) begin
                mean_vld_reg[0] <= 1'b0;
            end
        end
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (cmd.rd_item) begin
            x_reg   <= s_coeff_in;
            eob_reg <= s_end_of_batch;
            eou_reg <= s_end_of_utterance;
            idx_reg <= eff_idx;
        end
    end

    always_comb begin
        coeff_index_next = coeff_index_reg;
        frame_count_next = frame_count_reg;
        if (cmd.calc) begin
            if (wrap) begin
                coeff_index_next = '0;
                if (frame_count_reg != '1) begin
                    frame_count_next = frame_count_reg + FRAME_W'(1);
                end
            end else begin
                coeff_index_next = idx_inc[IDX_W-1:0];
            end
        end
        if (cmd.cnt_window) begin
            frame_count_next = window_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_index_reg <= '0;
            frame_count_reg <= '0;
            sweep_idx_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            coeff_index_reg <= coeff_index_next;
            frame_count_reg <= frame_count_next;
            if (cmd.sweep_clr) begin
                sweep_idx_reg <= '0;
            end else if (cmd.sweep_inc) begin
                sweep_idx_reg <= sweep_idx_reg + IDX_W'(1);
            end
            if (cmd.calc) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            m_coeff_reg <= diff_sat;
        end
    end

    // multiplier and divider
    always_ff @(posedge aclk) begin
        if (cmd.div_load_mean) begin
            dq_reg   <= DIV_W'(sum_mag) + half;
            rem_reg  <= '0;
            iter_reg <= ITER_W'(DIV_W - 1);
        end else if (cmd.div_load_decay) begin
            dq_reg   <= prod_reg + half;
            rem_reg  <= '0;
            iter_reg <= ITER_W'(DIV_W - 1);
        end else if (cmd.div_step) begin
            dq_reg   <= {dq_reg[DIV_W-2:0], ge};
            rem_reg  <= ge ? FRAME_W'(trial - {1'b0, frame_count_reg}) : trial[FRAME_W-1:0];
            iter_reg <= iter_reg - ITER_W'(1);
        end else if (cmd.mul_load) begin
            iter_reg <= ITER_W'(FRAME_W - 1);
        end else if (cmd.mul_step) begin
            iter_reg <= iter_reg - ITER_W'(1);
        end
        if (cmd.mul_load) begin
            prod_reg <= '0;
            wmul_reg <= window_reg;
        end else if (cmd.mul_step) begin
            prod_reg <= {prod_reg[DIV_W-2:0], 1'b0}
                      + (wmul_reg[FRAME_W-1] ? DIV_W'(sum_mag) : '0);
            wmul_reg <= {wmul_reg[FRAME_W-2:0], 1'b0};
        end
    end

    assign stat.eob        = eob_reg;
    assign stat.eou        = eou_reg;
    assign stat.cnt_gt_hwm = frame_count_reg > hwm_reg;
    assign stat.cnt_zero   = frame_count_reg == '0;
    assign stat.sweep_last = (NW'(sweep_idx_reg) + NW'(1)) == n_eff;
    assign stat.iter_zero  = iter_reg == '0;
    assign stat.out_free   = !m_valid_reg || m_ready;

    assign m_valid     = m_valid_reg;
    assign m_coeff_out = m_coeff_reg;

endmodule

### design/lcmn_ctrl.sv
// Controller: item handshake and the mean update and decay sweep sequence.
module lcmn_ctrl import lcmn_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  lcmn_stat_t stat,
    output lcmn_cmd_t  cmd
);

    typedef enum logic [3:0] {
        IDLE,
        CALC,
        CHECK_A,
        RD,
        LOAD_M,
        DIV_M,
        WR_M,
        MUL_LD,
        MUL,
        LOAD_D,
        DIV_D,
        WR_S,
        NEXT,
        FINISH,
        CHECK_B
    } state_t;

    state_t state_reg, state_next;
    logic   decay_reg, decay_next;
    logic   phase_b_reg, phase_b_next;
    logic   accept;

    assign s_ready = (state_reg == IDLE) && stat.out_free;
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next   = state_reg;
        decay_next   = decay_reg;
        phase_b_next = phase_b_reg;
        cmd          = '0;
        case (state_reg)
            IDLE: begin
                cmd.rd_item = accept;
                if (accept) state_next = CALC;
            end
            CALC: begin
                cmd.calc   = 1'b1;
                state_next = stat.eob ? CHECK_A : IDLE;
            end
            CHECK_A: begin
                cmd.sweep_clr = 1'b1;
                if (stat.cnt_gt_hwm) begin
                    decay_next   = 1'b1;
                    phase_b_next = 1'b0;
                    state_next   = RD;
                end else if (stat.eou && !stat.cnt_zero) begin
                    decay_next   = 1'b0;
                    phase_b_next = 1'b1;
                    state_next   = RD;
                end else begin
                    state_next = IDLE;
                end
            end
            RD: begin
                cmd.rd_sweep = 1'b1;
                state_next   = LOAD_M;
            end
            LOAD_M: begin
                cmd.div_load_mean = 1'b1;
                state_next        = DIV_M;
            end
            DIV_M: begin
                cmd.div_step = 1'b1;
                if (stat.iter_zero) state_next = WR_M;
            end
            WR_M: begin
                cmd.wr_mean = 1'b1;
                state_next  = decay_reg ? MUL_LD : NEXT;
            end
            MUL_LD: begin
                cmd.mul_load = 1'b1;
                state_next   = MUL;
            end
            MUL: begin
                cmd.mul_step = 1'b1;
                if (stat.iter_zero) state_next = LOAD_D;
            end
            LOAD_D: begin
                cmd.div_load_decay = 1'b1;
                state_next         = DIV_D;
            end
            DIV_D: begin
                cmd.div_step = 1'b1;
                if (stat.iter_zero) state_next = WR_S;
            end
            WR_S: begin
                cmd.wr_sum = 1'b1;
                state_next = NEXT;
            end
            NEXT: begin
                if (stat.sweep_last) begin
                    state_next = FINISH;
                end else begin
                    cmd.sweep_inc = 1'b1;
                    state_next    = RD;
                end
            end
            FINISH: begin
                cmd.cnt_window = decay_reg;
                state_next     = (!phase_b_reg && stat.eou) ? CHECK_B : IDLE;
            end
            CHECK_B: begin
                cmd.sweep_clr = 1'b1;
                if (!stat.cnt_zero) begin
                    decay_next   = stat.cnt_gt_hwm;
                    phase_b_next = 1'b1;
                    state_next   = RD;
                end else begin
                    state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            decay_reg   <= 1'b0;
            phase_b_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            decay_reg   <= decay_next;
            phase_b_reg <= phase_b_next;
        end
    end

endmodule

### design/live_cepstral_mean_normalizer.sv
// Top level of the live cepstral mean normalizer: controller and datapath.
// Each accepted item is registered, then its result is computed and registered in the CALC state.
// No new item is accepted before the controller is back in IDLE, nor while a result waits for the receiver.
// An update sweep walks the coefficient stores with one shared 56-step divider: per coefficient
// it divides the sum for the mean, and when the sums decay it also scales and divides them again.
// Reset (synchronous, active low) restores register defaults and marks the stores empty at once.
module live_cepstral_mean_normalizer import lcmn_pkg::*; #(
    parameter int MAX_COEFFS = DEFAULT_MAX_COEFFS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COEFF_W-1:0]    s_coeff_in,
    input  logic                  s_end_of_batch,
    input  logic                  s_end_of_utterance,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COEFF_W-1:0]    m_coeff_out,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    lcmn_cmd_t  cmd;
    lcmn_stat_t stat;

    lcmn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lcmn_datapath #(
        .MAX_COEFFS (MAX_COEFFS)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .stat               (stat),
        .s_coeff_in         (s_coeff_in),
        .s_end_of_batch     (s_end_of_batch),
        .s_end_of_utterance (s_end_of_utterance),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_coeff_out        (m_coeff_out),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata)
    );

endmodule
